// File: rtl/stdq_pkg.sv
// Shared types and constants for the sorted timer deadline queue.
// Depends on nothing; the top level, the compare unit and the checker import it.
`timescale 1ns / 1ps
`default_nettype none

package stdq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int DL_BITS_DEF = 32;
    localparam int ID_W        = 4;
    localparam int FIELD_DL_W  = 32;
    localparam int OCC_W       = 5;
    localparam int NUM_IDS     = 1 << ID_W;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_CANCEL = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_QUEUED = 2'd1,
        ST_FULL       = 2'd2,
        ST_DUP        = 2'd3
    } status_t;

    typedef struct packed {
        logic                  req_type;
        logic [ID_W-1:0]       entry_id;
        logic [FIELD_DL_W-1:0] deadline;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic                  head_valid;
        logic [ID_W-1:0]       head_id;
        logic [FIELD_DL_W-1:0] head_deadline;
        logic [OCC_W-1:0]      occupancy;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_START,
        S_INS_CMP,
        S_INS_FRONT,
        S_CAN_START,
        S_CAN_CMP,
        S_HEAD_RD,
        S_HEAD_CAP
    } state_t;

    // Flags from the shared compare unit for the slot just read
    typedef struct packed {
        logic later;   // slot deadline strictly greater than the key
        logic id_hit;  // slot holds the requested id
        logic last;    // slot is the highest filled one
    } cmp_res_t;

endpackage

`default_nettype wire

// File: rtl/sorted_timer_deadline_queue.sv
// Top level of the sorted timer deadline queue: sequencer, occupancy state, slot RAM.
// Depends on stdq_pkg, stdq_ram, stdq_cmp.
//
//  channel | valid     | stall     | payload | direction
//  --------+-----------+-----------+---------+----------
//  request | req_valid | req_stall | req     | in
//  result  | rsp_valid | rsp_stall | rsp     | out
//
// One item at a time; a rejected request goes straight to the head read, an insert
// into an empty queue writes slot 0 directly, any other insert walks down from the
// top slot shifting later entries up, and a cancel walks every filled slot. The walk
// reads one slot a cycle from the slot RAM.
// Reset clears the state, occupancy, queued mask, found flag and result valid; slot RAM needs no clearing.
// A result held by rsp_stall waits in the output register; a new item is taken
// meanwhile, and its own result waits for the register to drain.
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_deadline_queue
    import stdq_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEF,
    parameter int DEADLINE_BITS = DL_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SLOT_W = DEADLINE_BITS + ID_W;

    state_t                   state_reg, state_next;
    logic [ID_W-1:0]          id_reg;
    logic [DEADLINE_BITS-1:0] key_reg;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     found_reg, found_next;
    status_t                  status_reg, status_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [NUM_IDS-1:0]       mask_reg, mask_next;
    rsp_t                     rsp_reg, rsp_next;
    logic                     rsp_valid_reg;

    logic                              accept;
    logic                              load;
    logic [DEADLINE_BITS+FIELD_DL_W-1:0] key_ext;
    logic [DEADLINE_BITS-1:0]          key_in;
    logic [CNT_W-1:0]                  cnt_dec;
    logic [IDX_W-1:0]                  top_idx;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [SLOT_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]         ram_raddr;
    logic [SLOT_W-1:0]        ram_rdata;
    logic [DEADLINE_BITS-1:0] rd_dl;
    logic [ID_W-1:0]          rd_id;
    logic [SLOT_W-1:0]        new_slot;
    cmp_res_t                 cmp;

    logic [DEADLINE_BITS+FIELD_DL_W-1:0] head_ext;
    logic [CNT_W+OCC_W-1:0]              occ_ext;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // deadline kept to DEADLINE_BITS bits
    assign key_ext = {{DEADLINE_BITS{1'b0}}, req.deadline};
    assign key_in  = key_ext[DEADLINE_BITS-1:0];

    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign top_idx  = cnt_dec[IDX_W-1:0];
    assign rd_dl    = ram_rdata[DEADLINE_BITS-1:0];
    assign rd_id    = ram_rdata[SLOT_W-1 -: ID_W];
    assign new_slot = {id_reg, key_reg};

    stdq_ram
    #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    )
    u_slots
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stdq_cmp
    #(
        .DL_W  (DEADLINE_BITS),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    )
    u_cmp
    (
        .slot_dl (rd_dl),
        .slot_id (rd_id),
        .key_dl  (key_reg),
        .key_id  (id_reg),
        .idx     (idx_reg),
        .cnt     (cnt_reg),
        .res     (cmp)
    );

    // Next state and bookkeeping
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        status_next = status_reg;
        cnt_next    = cnt_reg;
        mask_next   = mask_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    if (req.req_type == REQ_CANCEL)
                    begin
                        if (!mask_reg[req.entry_id])
                        begin
                            status_next = ST_NOT_QUEUED;
                            state_next  = S_HEAD_RD;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            state_next  = S_CAN_START;
                        end
                    end
                    else if (mask_reg[req.entry_id])
                    begin
                        status_next = ST_DUP;
                        state_next  = S_HEAD_RD;
                    end
                    else if (cnt_reg >= CNT_W'(DEPTH))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_HEAD_RD;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        state_next  = S_INS_START;
                    end
                end
            end
            S_INS_START:
            begin
                if (cnt_reg == '0)
                begin
                    cnt_next          = cnt_reg + CNT_W'(1);
                    mask_next[id_reg] = 1'b1;
                    state_next        = S_HEAD_RD;
                end
                else
                begin
                    idx_next   = top_idx;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (cmp.later)
                begin
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_FRONT;
                    end
                    else
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    cnt_next          = cnt_reg + CNT_W'(1);
                    mask_next[id_reg] = 1'b1;
                    state_next        = S_HEAD_RD;
                end
            end
            S_INS_FRONT:
            begin
                cnt_next          = cnt_reg + CNT_W'(1);
                mask_next[id_reg] = 1'b1;
                state_next        = S_HEAD_RD;
            end
            S_CAN_START:
            begin
                state_next = S_CAN_CMP;
            end
            S_CAN_CMP:
            begin
                if (!found_reg && cmp.id_hit)
                begin
                    found_next = 1'b1;
                end
                if (cmp.last)
                begin
                    mask_next[id_reg] = 1'b0;
                    if (found_reg || cmp.id_hit)
                    begin
                        cnt_next = cnt_dec;
                    end
                    else
                    begin
                        status_next = ST_NOT_QUEUED;
                    end
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD_CAP;
            end
            S_HEAD_CAP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // RAM port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = new_slot;
        ram_raddr = '0;
        unique case (state_reg)
            S_INS_START:
            begin
                if (cnt_reg == '0)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_raddr = top_idx;
                end
            end
            S_INS_CMP:
            begin
                // write the later slot, or else the new entry, one slot up; fetch the one below it
                ram_we    = 1'b1;
                ram_waddr = idx_reg + IDX_W'(1);
                ram_raddr = idx_reg - IDX_W'(1);
                if (cmp.later)
                begin
                    ram_wdata = ram_rdata;
                end
            end
            S_INS_FRONT:
            begin
                ram_we = 1'b1;
            end
            S_CAN_CMP:
            begin
                // once the id is passed, each slot moves down one
                ram_we    = found_reg;
                ram_waddr = idx_reg - IDX_W'(1);
                ram_wdata = ram_rdata;
                ram_raddr = idx_reg + IDX_W'(1);
            end
            S_IDLE, S_CAN_START, S_HEAD_RD, S_HEAD_CAP:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign load     = (state_reg == S_HEAD_CAP) && (!rsp_valid_reg || !rsp_stall);
    assign head_ext = {{FIELD_DL_W{1'b0}}, rd_dl};
    assign occ_ext  = {{OCC_W{1'b0}}, cnt_reg};

    always_comb
    begin
        rsp_next.status        = status_reg;
        rsp_next.occupancy     = occ_ext[OCC_W-1:0];
        rsp_next.head_valid    = (cnt_reg != '0);
        rsp_next.head_id       = '0;
        rsp_next.head_deadline = '0;
        if (cnt_reg != '0)
        begin
            rsp_next.head_id       = rd_id;
            rsp_next.head_deadline = head_ext[FIELD_DL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            mask_reg      <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mask_reg  <= mask_next;
            found_reg <= found_next;
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        status_reg <= status_next;
        if (accept)
        begin
            id_reg  <= req.entry_id;
            key_reg <= key_in;
        end
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/stdq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module stdq_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/stdq_cmp.sv
// Shared compare unit used on every step of the slot walk.
// Depends on stdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stdq_cmp
    import stdq_pkg::*;
#(
    parameter int DL_W  = DL_BITS_DEF,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
)
(
    input  wire logic [DL_W-1:0]  slot_dl,
    input  wire logic [ID_W-1:0]  slot_id,
    input  wire logic [DL_W-1:0]  key_dl,
    input  wire logic [ID_W-1:0]  key_id,
    input  wire logic [IDX_W-1:0] idx,
    input  wire logic [CNT_W-1:0] cnt,
    output cmp_res_t              res
);

    logic [CNT_W-1:0] idx_inc;

    assign idx_inc    = CNT_W'(idx) + CNT_W'(1);
    assign res.later  = (slot_dl > key_dl);
    assign res.id_hit = (slot_id == key_id);
    assign res.last   = (idx_inc >= cnt);

endmodule

`default_nettype wire

// File: rtl/stdq_checker.sv
// Port-level checks for the sorted timer deadline queue, bound to the top level.
// Depends on stdq_pkg and sorted_timer_deadline_queue.
`timescale 1ns / 1ps
`default_nettype none

module stdq_checker
    import stdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

    // a held result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // the block takes one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while a walk is in progress");

    // an empty queue shows no head and no entries
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.head_valid |->
            rsp.head_id == '0 && rsp.head_deadline == '0 && rsp.occupancy == '0)
        else $error("empty queue reports a head");

    // a full rejection only with every slot in use
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.occupancy == FULL_OCC && rsp.head_valid)
        else $error("queue full reported below capacity");

endmodule

bind sorted_timer_deadline_queue stdq_checker
#(
    .DEPTH (DEPTH)
)
u_stdq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
